// File: hdl/glvms_pkg.sv
package glvms_pkg;

    // Fixed-point format of the deformation gradient entries.
    localparam int FRACTION_BITS = 12;
    // Right shift that brings the squared sum to the Q16.16-squared scale.
    localparam int SUM_SHIFT = 4 * FRACTION_BITS - 30;

    localparam int ID_W = 16;
    localparam int F_W = 16;
    localparam int PROD_W = 2 * F_W;
    localparam int E_W = PROD_W + 3;
    localparam int MAG_W = 32;
    localparam int SQ_W = 2 * MAG_W;
    localparam int PSUM_W = SQ_W + 2;
    localparam int SUM_W = SQ_W + 4;
    localparam int ROOT_W = 32;
    localparam int REM_W = SUM_W + 2;

    localparam logic signed [E_W-1:0] UNIT_DIAG = E_W'(1) <<< (2 * FRACTION_BITS);
    // The root saturates once the quotient by three reaches 2^64.
    localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(3) << 64;

    typedef struct packed {
        logic [ID_W-1:0]        particle_id;
        logic signed [F_W-1:0]  deform_xx;
        logic signed [F_W-1:0]  deform_xy;
        logic signed [F_W-1:0]  deform_xz;
        logic signed [F_W-1:0]  deform_yx;
        logic signed [F_W-1:0]  deform_yy;
        logic signed [F_W-1:0]  deform_yz;
        logic signed [F_W-1:0]  deform_zx;
        logic signed [F_W-1:0]  deform_zy;
        logic signed [F_W-1:0]  deform_zz;
    } t_request;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic [ROOT_W-1:0] equivalent_strain;
    } t_result;

    // Scaled squared sum handed from the strain stages to the root stages.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SUM_W-1:0] radicand;
        logic             sat;
    } t_root_in;

endpackage

// File: hdl/glvms_strain.sv
module glvms_strain
    import glvms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_request i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_root_in o_data
);

    // Entry pairs of F^T F: three diagonal, then xy, yz, xz.
    localparam int PA [6] = '{0, 1, 2, 0, 1, 0};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    logic signed [F_W-1:0]    f [3][3];
    logic [6:1]               r_v;
    logic [6:1]               rdy;
    logic [ID_W-1:0]          r_id [6:1];
    logic signed [PROD_W-1:0] r_prod [6][3];
    logic signed [PROD_W-1:0] n_prod [6][3];
    logic signed [E_W-1:0]    r_e [6];
    logic signed [E_W-1:0]    n_e [6];
    logic [MAG_W-1:0]         r_mag [6];
    logic [MAG_W-1:0]         n_mag [6];
    logic [SQ_W-1:0]          r_sq [6];
    logic [SQ_W-1:0]          n_sq [6];
    logic [PSUM_W-1:0]        r_dsum;
    logic [PSUM_W-1:0]        r_ssum;
    logic [SUM_W-1:0]         n_total;
    logic [SUM_W-1:0]         n_rad;
    logic [SUM_W-1:0]         r_rad;
    logic                     r_sat;

    assign f[0][0] = i_data.deform_xx;
    assign f[0][1] = i_data.deform_xy;
    assign f[0][2] = i_data.deform_xz;
    assign f[1][0] = i_data.deform_yx;
    assign f[1][1] = i_data.deform_yy;
    assign f[1][2] = i_data.deform_yz;
    assign f[2][0] = i_data.deform_zx;
    assign f[2][1] = i_data.deform_zy;
    assign f[2][2] = i_data.deform_zz;

    // A stage takes new data when it is empty or its successor moves on.
    assign rdy[6] = !r_v[6] || i_ready;
    assign rdy[5] = !r_v[5] || rdy[6];
    assign rdy[4] = !r_v[4] || rdy[5];
    assign rdy[3] = !r_v[3] || rdy[4];
    assign rdy[2] = !r_v[2] || rdy[3];
    assign rdy[1] = !r_v[1] || rdy[2];
    assign o_ready = rdy[1];

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[p][k] = f[k][PA[p]] * f[k][PB[p]];
            end
        end
    end

    always_comb begin
        logic signed [E_W-1:0] acc;
        for (int p = 0; p < 6; p++) begin
            acc = E_W'(r_prod[p][0]) + E_W'(r_prod[p][1]) + E_W'(r_prod[p][2]);
            n_e[p] = (p < 3) ? acc - UNIT_DIAG : acc;
        end
    end

    always_comb begin
        logic signed [E_W:0] diff;
        for (int p = 0; p < 3; p++) begin
            diff = (E_W+1)'(r_e[p]) - (E_W+1)'(r_e[(p + 1) % 3]);
            n_mag[p] = diff[E_W] ? MAG_W'(-diff) : MAG_W'(diff);
        end
        for (int p = 3; p < 6; p++) begin
            n_mag[p] = r_e[p][E_W-1] ? MAG_W'(-r_e[p]) : MAG_W'(r_e[p]);
        end
    end

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            n_sq[p] = r_mag[p] * r_mag[p];
        end
    end

    // Shear squares count six times relative to the normal differences.
    assign n_total = SUM_W'(r_dsum) + (SUM_W'(r_ssum) << 2) + (SUM_W'(r_ssum) << 1);
    assign n_rad   = n_total >> SUM_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[1]) r_v[1] <= i_valid;
            if (rdy[2]) r_v[2] <= r_v[1];
            if (rdy[3]) r_v[3] <= r_v[2];
            if (rdy[4]) r_v[4] <= r_v[3];
            if (rdy[5]) r_v[5] <= r_v[4];
            if (rdy[6]) r_v[6] <= r_v[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_id[1] <= i_data.particle_id;
            r_prod  <= n_prod;
        end
        if (rdy[2]) begin
            r_id[2] <= r_id[1];
            r_e     <= n_e;
        end
        if (rdy[3]) begin
            r_id[3] <= r_id[2];
            r_mag   <= n_mag;
        end
        if (rdy[4]) begin
            r_id[4] <= r_id[3];
            r_sq    <= n_sq;
        end
        if (rdy[5]) begin
            r_id[5] <= r_id[4];
            r_dsum  <= PSUM_W'(r_sq[0]) + PSUM_W'(r_sq[1]) + PSUM_W'(r_sq[2]);
            r_ssum  <= PSUM_W'(r_sq[3]) + PSUM_W'(r_sq[4]) + PSUM_W'(r_sq[5]);
        end
        if (rdy[6]) begin
            r_id[6] <= r_id[5];
            r_rad   <= n_rad;
            r_sat   <= n_rad >= SAT_LIMIT;
        end
    end

    assign o_valid         = r_v[6];
    assign o_data.id       = r_id[6];
    assign o_data.radicand = r_rad;
    assign o_data.sat      = r_sat;

endmodule

// File: hdl/glvms_root.sv
module glvms_root
    import glvms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_root_in i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_result  o_data
);

    // Finds the largest r with 3*r*r <= radicand, one result bit per stage.
    logic [ROOT_W-1:0] r_v;
    logic [ROOT_W-1:0] rdy;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [ROOT_W-1:0] r_sat;
    logic [ID_W-1:0]   r_id   [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - j;
        logic              src_v;
        logic [REM_W-1:0]  src_rem;
        logic [ROOT_W-1:0] src_root;
        logic              src_sat;
        logic [ID_W-1:0]   src_id;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  step;
        logic              take;

        if (j == 0) begin : g_first
            assign src_v    = i_valid;
            assign src_rem  = REM_W'(i_data.radicand);
            assign src_root = '0;
            assign src_sat  = i_data.sat;
            assign src_id   = i_data.id;
        end else begin : g_next
            assign src_v    = r_v[j-1];
            assign src_rem  = r_rem[j-1];
            assign src_root = r_root[j-1];
            assign src_sat  = r_sat[j-1];
            assign src_id   = r_id[j-1];
        end

        if (j == ROOT_W - 1) begin : g_last
            assign rdy[j] = !r_v[j] || i_ready;
        end else begin : g_mid
            assign rdy[j] = !r_v[j] || rdy[j+1];
        end

        // 3*((r+2^b)^2 - r^2) with the lower root bits still zero.
        assign trial = (REM_W'(src_root) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));
        assign step  = trial + (trial << 1);
        assign take  = step <= src_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (rdy[j]) begin
                r_v[j] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[j]) begin
                r_rem[j]  <= take ? src_rem - step : src_rem;
                r_root[j] <= take ? (src_root | (ROOT_W'(1) << BIT)) : src_root;
                r_sat[j]  <= src_sat;
                r_id[j]   <= src_id;
            end
        end
    end

    assign o_ready                  = rdy[0];
    assign o_valid                  = r_v[ROOT_W-1];
    assign o_data.result_id         = r_id[ROOT_W-1];
    assign o_data.equivalent_strain = r_sat[ROOT_W-1] ? '1 : r_root[ROOT_W-1];

endmodule

// File: hdl/green_lagrange_von_mises_strain_unit.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | i_valid / o_stall  | i_request (t_request)
// result   | out       | o_valid / i_stall  | o_result  (t_result)
//
// One request enters per cycle while nothing stalls; its result passes through
// the strain arithmetic stages, then 32 root stages that each settle one bit
// of the square root.
// Reset is synchronous and active low; it clears only the stage valid bits.
// Empty stages keep filling while the output is stalled, so o_stall rises
// only when every stage holds a request.
module green_lagrange_von_mises_strain_unit
    import glvms_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_request i_request,
    output logic     o_valid,
    input  logic     i_stall,
    output t_result  o_result
);

    logic     strain_ready;
    logic     mid_valid;
    logic     root_ready;
    t_root_in mid_data;

    // Green-Lagrange strain and the scaled sum of squares under the root.
    glvms_strain u_strain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (strain_ready),
        .i_data  (i_request),
        .o_valid (mid_valid),
        .i_ready (root_ready),
        .o_data  (mid_data)
    );

    // Bit-per-stage square root of one third of the sum, with saturation.
    glvms_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .o_ready (root_ready),
        .i_data  (mid_data),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_data  (o_result)
    );

    assign o_stall = !strain_ready;

`ifndef NO_ASSERTIONS
    // The first cycle after reset shows no result.
    a_reset_empty: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // A free output frees the whole pipeline, so requests are never held off.
    a_no_stall_when_free: assert property (@(posedge i_clk)
        !i_stall |-> !o_stall)
        else $error("request stalled while result side is free");
`endif

endmodule

// File: verif/tb_green_lagrange_von_mises_strain_unit.sv
module tb_green_lagrange_von_mises_strain_unit;
    import glvms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Clock, reset and the two channels of the unit.
    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    t_request request = '0;
    logic     res_valid;
    logic     res_stall = 1'b1;
    t_result  result;

    // Results that the strain computation still owes, oldest first.
    t_result  owed_strains[$];
    int       error_count = 0;
    int       quiet_cycles = 0;
    // While set, the result side holds off completely so the pipeline fills up.
    bit       hold_results = 1'b0;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 60;

    always #5 clk = ~clk;

    green_lagrange_von_mises_strain_unit u_top (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_valid   (req_valid),
        .o_stall   (req_stall),
        .i_request (request),
        .o_valid   (res_valid),
        .i_stall   (res_stall),
        .o_result  (result)
    );

    // Integer square root rounded down, one result bit per pass.
    function automatic logic [31:0] floor_root(input logic [63:0] radicand);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root[31:0];
    endfunction

    // Equivalent strain of one deformation gradient. The strain matrix is kept
    // as F^T F - I with 2*FRACTION_BITS fraction bits, which is twice E, so the
    // squared sum needs a divide by three and a shift to land on Q16.16 squared.
    function automatic t_result strain_of(input t_request req);
        logic signed [63:0]  grad[3][3];
        logic signed [63:0]  twice_e[3][3];
        logic signed [63:0]  acc;
        logic signed [63:0]  diff;
        logic [127:0]        sq_sum;
        t_result             res;
        grad[0][0] = req.deform_xx; grad[0][1] = req.deform_xy; grad[0][2] = req.deform_xz;
        grad[1][0] = req.deform_yx; grad[1][1] = req.deform_yy; grad[1][2] = req.deform_yz;
        grad[2][0] = req.deform_zx; grad[2][1] = req.deform_zy; grad[2][2] = req.deform_zz;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    acc += grad[k][r] * grad[k][c];
                end
                twice_e[r][c] = (r == c) ? acc - (64'sd1 <<< (2 * FRACTION_BITS)) : acc;
            end
        end
        sq_sum = '0;
        for (int i = 0; i < 3; i++) begin
            diff = twice_e[i][i] - twice_e[(i + 1) % 3][(i + 1) % 3];
            sq_sum += 128'(diff) * 128'(diff);
        end
        sq_sum += 128'd6 * (128'(twice_e[0][1]) * 128'(twice_e[0][1]));
        sq_sum += 128'd6 * (128'(twice_e[1][2]) * 128'(twice_e[1][2]));
        sq_sum += 128'd6 * (128'(twice_e[0][2]) * 128'(twice_e[0][2]));
        sq_sum = (sq_sum >> SUM_SHIFT) / 3;
        res.result_id = req.particle_id;
        res.equivalent_strain = (sq_sum[127:64] != 0) ? 32'hFFFF_FFFF
                                                      : floor_root(sq_sum[63:0]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Offers one request, with a random gap first, and waits for acceptance.
    // Valid stays high after acceptance so that back-to-back requests follow
    // without a gap; a gap drops it first.
    task automatic send_request(input t_request req);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) begin
            gap = 0;
        end
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        request <= req;
        do @(posedge clk); while (req_stall);
        owed_strains.push_back(strain_of(req));
    endtask

    function automatic logic signed [15:0] random_entry();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'sh1000 + 16'($signed($urandom_range(0, 200)) - 100);
            2: return 16'($signed($urandom_range(0, 2000)) - 1000);
            3: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 16000)) - 8000);
        endcase
    endfunction

    function automatic t_request identity_request(input logic [15:0] id);
        t_request req;
        req = '0;
        req.particle_id = id;
        req.deform_xx = 16'sh1000;
        req.deform_yy = 16'sh1000;
        req.deform_zz = 16'sh1000;
        return req;
    endfunction

    // Zero strain, all-zero gradient, both extremes of every entry, pure
    // stretch, pure shear and rotation-like cases, then each entry alone at an extreme.
    task automatic test_directed();
        t_request req;
        send_request(identity_request(16'h0000));
        req = '0; req.particle_id = 16'hFFFF; send_request(req);
        req = '1; send_request(req);
        req = {16'h5A5A, {9{16'sh7FFF}}}; send_request(req);
        req = {16'hA5A5, {9{16'sh8000}}}; send_request(req);
        req = identity_request(16'd1); req.deform_xx = 16'sh2000; send_request(req);
        req = identity_request(16'd2); req.deform_xy = 16'sh0800; send_request(req);
        req = identity_request(16'd3); req.deform_yz = -16'sh0800; send_request(req);
        req = identity_request(16'd4); req.deform_zx = 16'sh0001; send_request(req);
        req = '0; req.particle_id = 16'd5;
        req.deform_xy = 16'sh1000; req.deform_yx = -16'sh1000; req.deform_zz = 16'sh1000;
        send_request(req);
        req = identity_request(16'd6); req.deform_zz = 16'sh8000; send_request(req);
        req = identity_request(16'd7); req.deform_yy = 16'sh7FFF; send_request(req);
        for (int i = 0; i < 9; i++) begin
            req = '0;
            req.particle_id = 16'(100 + i);
            req[16 * (8 - i) +: 16] = (i % 2) ? 16'sh8000 : 16'sh7FFF;
            send_request(req);
        end
    endtask

    task automatic test_random(input int count);
        t_request req;
        for (int n = 0; n < count; n++) begin
            req.particle_id = 16'($urandom);
            req.deform_xx = random_entry(); req.deform_xy = random_entry();
            req.deform_xz = random_entry(); req.deform_yx = random_entry();
            req.deform_yy = random_entry(); req.deform_yz = random_entry();
            req.deform_zx = random_entry(); req.deform_zy = random_entry();
            req.deform_zz = random_entry();
            send_request(req);
        end
    endtask

    // The result side freezes for a long stretch while requests keep coming,
    // so every stage fills and the unit must stall its input.
    task automatic test_backpressure();
        hold_results = 1'b1;
        fork
            test_random(60);
            begin
                repeat (300) @(posedge clk);
                hold_results = 1'b0;
            end
        join
    endtask

    // Result side: random stalls, mostly short, a few long, with calm stretches.
    initial begin
        int run;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_results) begin
                res_stall <= 1'b1;
                @(posedge clk);
            end else begin
                res_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 3);
                if (run > 0 && !hold_results) begin
                    res_stall <= 1'b1;
                    repeat (run) @(posedge clk);
                end
            end
        end
    end

    // Checks each accepted result against the oldest owed one and watches for
    // a stretch in which nothing moves.
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (res_valid && !res_stall) begin
                if (owed_strains.size() == 0) begin
                    report_mismatch("unexpected result id", result.result_id, 0);
                end else begin
                    want = owed_strains.pop_front();
                    if (result.result_id !== want.result_id) begin
                        report_mismatch("result_id", result.result_id, want.result_id);
                    end
                    if (result.equivalent_strain !== want.equivalent_strain) begin
                        report_mismatch("equivalent_strain", result.equivalent_strain,
                                        want.equivalent_strain);
                    end
                end
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_green_lagrange_von_mises_strain_unit: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(240);
        test_backpressure();
        test_random(230);
        req_valid <= 1'b0;
        while (owed_strains.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && owed_strains.size() == 0) begin
            $display("tb_green_lagrange_von_mises_strain_unit: done, clean");
        end else begin
            $display("tb_green_lagrange_von_mises_strain_unit: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/glvms_pkg.sv
hdl/glvms_strain.sv
hdl/glvms_root.sv
hdl/green_lagrange_von_mises_strain_unit.sv
verif/tb_green_lagrange_von_mises_strain_unit.sv
